### sv/ghh_pkg.sv
// shared types and constants for the gaze heat map histogram
// no dependencies; imported by every module of the block
`default_nettype none

package ghh_pkg;

    localparam int BINS_PER_AXIS_DEF = 10;
    localparam int FRACTION_BITS_DEF = 12;

    localparam int COUNT_W = 16;
    localparam int LEVEL_W = 8;
    localparam int RATIO_W = 16;
    localparam int INDEX_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [RATIO_W-1:0] ratio_x;
        logic signed [RATIO_W-1:0] ratio_y;
        logic [INDEX_W-1:0]        bin_index;
    } ghh_in_t;

    typedef struct packed {
        logic               accepted;
        logic [COUNT_W-1:0] bin_count;
        logic [LEVEL_W-1:0] bin_level;
        logic [COUNT_W-1:0] peak_count;
    } ghh_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ghh_div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIN,
        ST_ADDR,
        ST_READ,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } ghh_state_t;

endpackage

`default_nettype wire

### sv/ghh_bin_store.sv
// bin counter memory: one shared port address, registered read data
// per-entry valid bits make never-written bins read as zero; uses ghh_pkg
`default_nettype none

module ghh_bin_store #(
    parameter int DEPTH  = ghh_pkg::BINS_PER_AXIS_DEF * ghh_pkg::BINS_PER_AXIS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           addr,
    input  wire logic [ghh_pkg::COUNT_W-1:0] wr_data,
    output logic      [ghh_pkg::COUNT_W-1:0] rd_data
);
    import ghh_pkg::*;

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_hit_reg;

    // valid bits clear at reset, entries become live on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### sv/ghh_level_div.sv
// serial restoring divider for level = floor(255 * count / peak)
// one quotient bit per cycle; uses ghh_pkg
`default_nettype none

module ghh_level_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ghh_pkg::COUNT_W-1:0] count,
    input  wire logic [ghh_pkg::COUNT_W-1:0] peak,
    output ghh_pkg::ghh_div_status_t         status,
    output logic      [ghh_pkg::LEVEL_W-1:0] level
);
    import ghh_pkg::*;

    localparam int PROD_W = COUNT_W + LEVEL_W;
    localparam int STEP_W = $clog2(LEVEL_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [COUNT_W-1:0]  rem_reg;
    logic [LEVEL_W-1:0]  low_reg;
    logic [LEVEL_W-1:0]  quot_reg;
    logic [COUNT_W-1:0]  divisor_reg;
    logic                zero_reg;

    logic [PROD_W-1:0]   scaled;
    logic [COUNT_W:0]    trial;
    logic                fits;
    logic [COUNT_W:0]    diff;

    // 255 * count as (count << 8) - count
    assign scaled = {count, {LEVEL_W{1'b0}}} - PROD_W'(count);
    assign trial  = {rem_reg, low_reg[LEVEL_W-1]};
    assign fits   = trial >= {1'b0, divisor_reg};
    assign diff   = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(LEVEL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits the count width
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= scaled[PROD_W-1:LEVEL_W];
            low_reg     <= scaled[LEVEL_W-1:0];
            quot_reg    <= '0;
            divisor_reg <= peak;
            zero_reg    <= (peak == '0);
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            low_reg  <= {low_reg[LEVEL_W-2:0], 1'b0};
            quot_reg <= {quot_reg[LEVEL_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign level       = zero_reg ? '0 : quot_reg;

endmodule

`default_nettype wire

### sv/gaze_heatmap_histogram_core.sv
// gaze heat map histogram, top level: sequencer, bin counter memory, level divider
// depends on ghh_pkg, ghh_bin_store and ghh_level_div
//
// usage
//   sample channel: sample_valid / sample_stall / sample_word. kind selects a
//   gaze sample (counted when both ratios lie in [0, 1.0]) or a read of one bin
//   result channel: result_valid / result_stall / result_word, one word per item
//   with accepted flag, bin count, level = floor(255 * count / peak) and peak
//   sequence: one item at a time; the next item is taken once the sequencer is
//   back in idle. each item steps through the binning, address, memory read,
//   update (read-modify-write) and divider start states, then the serial level
//   divider, one quotient bit per cycle (8 bits), and the done state
//   sample_stall is high whenever the sequencer is not idle
//   a finished word waits in the output register while the receiver stalls; the
//   next item is still accepted and runs up to its result, then holds there
//   reset: all bins read as zero (per-bin valid bits cleared at once), peak is
//   zero, the result register is empty; no clearing pass is needed
`default_nettype none

module gaze_heatmap_histogram_core #(
    parameter int BINS_PER_AXIS = ghh_pkg::BINS_PER_AXIS_DEF,
    parameter int FRACTION_BITS = ghh_pkg::FRACTION_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_stall,
    input  wire ghh_pkg::ghh_in_t sample_word,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output ghh_pkg::ghh_out_t     result_word
);
    import ghh_pkg::*;

    localparam int BIN_TOTAL = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int ADDR_W    = $clog2(BIN_TOTAL);
    localparam int BIN_W     = $clog2(BINS_PER_AXIS);
    localparam int BINS_W    = $clog2(BINS_PER_AXIS + 1);
    localparam int PROD_W    = RATIO_W - 1 + BINS_W;
    localparam int CMP_W     = (ADDR_W + 1 > INDEX_W) ? ADDR_W + 1 : INDEX_W;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1 << FRACTION_BITS);

    // {in range, bin} for one axis
    function automatic logic [BIN_W:0] axis_bin(input logic [RATIO_W-1:0] r);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quo;
        logic              ok;
        logic [BIN_W-1:0]  b;
        ok   = !r[RATIO_W-1] && (r <= RATIO_ONE);
        prod = PROD_W'(r[RATIO_W-2:0]) * PROD_W'(BINS_PER_AXIS);
        quo  = prod >> FRACTION_BITS;
        // a ratio of exactly 1.0 lands one past the grid, fold it into the last bin
        if (quo > PROD_W'(BINS_PER_AXIS - 1))
        begin
            b = BIN_W'(BINS_PER_AXIS - 1);
        end
        else
        begin
            b = quo[BIN_W-1:0];
        end
        return {ok, b};
    endfunction

    ghh_state_t state_reg, state_next;

    ghh_in_t             item_reg;
    logic [BIN_W-1:0]    bx_reg, bx_next;
    logic [BIN_W-1:0]    by_reg, by_next;
    logic                ok_reg, ok_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  peak_reg, peak_next;
    logic                result_valid_reg, result_valid_next;
    ghh_out_t            result_word_reg, result_word_next;

    logic                accept;
    logic                out_free;
    logic                mem_rd_en;
    logic                mem_wr_en;
    logic [COUNT_W-1:0]  mem_rd_data;
    logic [COUNT_W-1:0]  bumped;
    logic                div_start;
    ghh_div_status_t     div_status;
    logic [LEVEL_W-1:0]  div_level;
    logic [BIN_W:0]      x_bin;
    logic [BIN_W:0]      y_bin;
    logic [CMP_W-1:0]    read_index;
    logic                is_sample;

    assign accept     = sample_valid && !sample_stall;
    assign out_free   = !result_valid_reg || !result_stall;
    assign x_bin      = axis_bin(item_reg.ratio_x);
    assign y_bin      = axis_bin(item_reg.ratio_y);
    assign read_index = CMP_W'(item_reg.bin_index);
    assign is_sample  = (item_reg.kind == KIND_SAMPLE);
    // saturating increment
    assign bumped     = (mem_rd_data == COUNT_MAX) ? mem_rd_data : mem_rd_data + 1'b1;

    ghh_bin_store #(
        .DEPTH  (BIN_TOTAL),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .wr_en   (mem_wr_en),
        .addr    (addr_reg),
        .wr_data (bumped),
        .rd_data (mem_rd_data)
    );

    ghh_level_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .count  (count_reg),
        .peak   (peak_reg),
        .status (div_status),
        .level  (div_level)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            peak_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            peak_reg         <= peak_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= sample_word;
        end
        bx_reg          <= bx_next;
        by_reg          <= by_next;
        ok_reg          <= ok_next;
        addr_reg        <= addr_next;
        count_reg       <= count_next;
        result_word_reg <= result_word_next;
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        bx_next           = bx_reg;
        by_next           = by_reg;
        ok_next           = ok_reg;
        addr_next         = addr_reg;
        count_next        = count_reg;
        peak_next         = peak_reg;
        result_valid_next = result_valid_reg;
        result_word_next  = result_word_reg;
        mem_rd_en         = 1'b0;
        mem_wr_en         = 1'b0;
        div_start         = 1'b0;
        sample_stall      = 1'b1;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN:
            begin
                // per-axis binning, or the range check of a read
                bx_next = x_bin[BIN_W-1:0];
                by_next = y_bin[BIN_W-1:0];
                if (is_sample)
                begin
                    ok_next = x_bin[BIN_W] && y_bin[BIN_W];
                end
                else
                begin
                    ok_next = read_index < CMP_W'(BIN_TOTAL);
                end
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                if (is_sample)
                begin
                    addr_next = ADDR_W'(by_reg) * ADDR_W'(BINS_PER_AXIS) + ADDR_W'(bx_reg);
                end
                else
                begin
                    addr_next = read_index[ADDR_W-1:0];
                end
                state_next = ST_READ;
            end
            ST_READ:
            begin
                mem_rd_en  = ok_reg;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!ok_reg)
                begin
                    count_next = '0;
                end
                else if (is_sample)
                begin
                    mem_wr_en  = 1'b1;
                    count_next = bumped;
                    if (bumped > peak_reg)
                    begin
                        peak_next = bumped;
                    end
                end
                else
                begin
                    count_next = mem_rd_data;
                end
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold here until the output register frees up
                if (out_free)
                begin
                    result_valid_next           = 1'b1;
                    result_word_next.accepted   = is_sample && ok_reg;
                    result_word_next.bin_count  = count_reg;
                    result_word_next.bin_level  = div_level;
                    result_word_next.peak_count = peak_reg;
                    state_next                  = ST_IDLE;
                end
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

`ifndef ASSERT_OFF
    // the peak only ever grows
    assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= $past(peak_reg))
        else $error("peak count decreased");

    // no bin ever exceeds the peak
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_word.bin_count <= result_word.peak_count)
        else $error("bin count above peak");

    // a counted sample leaves a nonzero bin
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.accepted |-> result_word.bin_count != '0)
        else $error("accepted sample with empty bin");

    // a bin at the peak shows full level
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.bin_count == result_word.peak_count
            && result_word.peak_count != '0
        |-> result_word.bin_level == {LEVEL_W{1'b1}})
        else $error("peak bin not at full level");

    // after a start the divider is busy and the sequencer is in its divide state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_status.busy && state_reg == ST_DIVIDE)
        else $error("divider failed to start");
`endif

endmodule

`default_nettype wire

### sim/ghh_heatmap_checker.sv
// result checker for the gaze heat map histogram: keeps a shadow copy of the
// bin counters and peak, predicts one result word per accepted input word
// depends on ghh_pkg; instantiated by tb_gaze_heatmap_histogram_core

module ghh_heatmap_checker #(
    parameter int BINS_PER_AXIS = ghh_pkg::BINS_PER_AXIS_DEF,
    parameter int FRACTION_BITS = ghh_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  ghh_pkg::ghh_in_t  sample_word,
    input  logic              result_valid,
    input  logic              result_stall,
    input  ghh_pkg::ghh_out_t result_word,
    output int                error_count,
    output int                pending_count
);
    import ghh_pkg::*;

    localparam int BIN_TOTAL = BINS_PER_AXIS * BINS_PER_AXIS;
    localparam int RATIO_ONE = 1 << FRACTION_BITS;
    localparam int LEVEL_TOP = 255;
    localparam int REPORT_MAX = 10;

    logic [COUNT_W-1:0] shadow_counts [BIN_TOTAL];
    logic [COUNT_W-1:0] shadow_peak;
    ghh_out_t           predicted_results [$];
    ghh_out_t           want_word;
    int                 mismatches;

    // bin on one axis, -1 when the ratio lies outside [0, 1.0]
    function automatic int axis_bin_of(input logic signed [RATIO_W-1:0] ratio);
        int value;
        int bin;
        value = int'(ratio);
        if (value < 0 || value > RATIO_ONE)
            return -1;
        bin = (value * BINS_PER_AXIS) >> FRACTION_BITS;
        if (bin > BINS_PER_AXIS - 1)
            bin = BINS_PER_AXIS - 1;
        return bin;
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of_count(input logic [COUNT_W-1:0] count);
        int scaled;
        if (shadow_peak == '0)
            return '0;
        scaled = (LEVEL_TOP * int'(count)) / int'(shadow_peak);
        if (scaled > LEVEL_TOP)
            scaled = LEVEL_TOP;
        return scaled[LEVEL_W-1:0];
    endfunction

    // updates the shadow histogram and returns the word the block should give
    function automatic ghh_out_t heat_result_for(input ghh_in_t word);
        ghh_out_t           res;
        int                 bx;
        int                 by;
        int                 idx;
        logic [COUNT_W-1:0] count;
        res = '0;
        if (word.kind == KIND_SAMPLE)
        begin
            bx = axis_bin_of(word.ratio_x);
            by = axis_bin_of(word.ratio_y);
            if (bx >= 0 && by >= 0)
            begin
                idx = bx + by * BINS_PER_AXIS;
                count = shadow_counts[idx];
                if (count != COUNT_MAX)
                    count = count + 1'b1;
                shadow_counts[idx] = count;
                if (count > shadow_peak)
                    shadow_peak = count;
                res.accepted  = 1'b1;
                res.bin_count = count;
                res.bin_level = level_of_count(count);
            end
        end
        else
        begin
            idx = int'(word.bin_index);
            if (idx < BIN_TOTAL)
            begin
                res.bin_count = shadow_counts[idx];
                res.bin_level = level_of_count(shadow_counts[idx]);
            end
        end
        res.peak_count = shadow_peak;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BIN_TOTAL; i++)
                shadow_counts[i] = '0;
            shadow_peak = '0;
            predicted_results.delete();
            mismatches = 0;
            error_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX)
                        $display({"%0t: result word with none expected:",
                                  " acc %0d cnt %0d lvl %0d pk %0d"},
                                 $realtime, result_word.accepted, result_word.bin_count,
                                 result_word.bin_level, result_word.peak_count);
                end
                else
                begin
                    want_word = predicted_results.pop_front();
                    if (result_word.accepted   !== want_word.accepted  ||
                        result_word.bin_count  !== want_word.bin_count ||
                        result_word.bin_level  !== want_word.bin_level ||
                        result_word.peak_count !== want_word.peak_count)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_MAX)
                            $display({"%0t: mismatch: exp acc %0d cnt %0d lvl %0d pk %0d,",
                                      " got acc %0d cnt %0d lvl %0d pk %0d"},
                                     $realtime, want_word.accepted, want_word.bin_count,
                                     want_word.bin_level, want_word.peak_count,
                                     result_word.accepted, result_word.bin_count,
                                     result_word.bin_level, result_word.peak_count);
                    end
                end
            end
            if (sample_valid && !sample_stall)
                predicted_results.push_back(heat_result_for(sample_word));
            error_count <= mismatches;
            pending_count <= predicted_results.size();
        end
    end

endmodule

### sim/tb_gaze_heatmap_histogram_core.sv
// testbench top for gaze_heatmap_histogram_core: clock, reset, input words,
// result-side stalls and the verdict; checking is done by ghh_heatmap_checker
// depends on ghh_pkg, gaze_heatmap_histogram_core and ghh_heatmap_checker

module tb_gaze_heatmap_histogram_core;
    import ghh_pkg::*;

    localparam int BINS = BINS_PER_AXIS_DEF;
    localparam int FRAC = FRACTION_BITS_DEF;
    localparam int RATIO_ONE = 1 << FRAC;
    localparam int BIN_TOTAL = BINS * BINS;
    localparam int INDEX_TOP = (1 << INDEX_W) - 1;
    // leave plenty of time after the last result
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 400;
    // one bin hit back to back
    localparam int HOT_WORDS = 60;
    localparam int HOT_LO = (3 * RATIO_ONE + BINS - 1) / BINS;
    localparam int HOT_HI = (4 * RATIO_ONE - 1) / BINS;

    logic     clk;
    logic     rst_n;
    logic     sample_valid;
    logic     sample_stall;
    ghh_in_t  sample_word;
    logic     result_valid;
    logic     result_stall;
    ghh_out_t result_word;

    int       error_count;
    int       pending_count;
    // no idling on either side while set
    logic     quiet_mode;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int       hold_requests;

    gaze_heatmap_histogram_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    ghh_heatmap_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .sample_word   (sample_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_word   (result_word),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #80000000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall stretches, plus a long hold-off on request
    initial
    begin : receiver
        int hold_served;
        int span;
        int pick;
        hold_served = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                // long hold-off, counted here so the sender keeps pushing
                hold_served = hold_requests;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (quiet_mode)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    result_stall <= 1'b0;
                    span = $urandom_range(1, 8);
                end
                else if (pick < 96)
                begin
                    result_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end
                else
                begin
                    result_stall <= 1'b1;
                    span = $urandom_range(10, 60);
                end
                repeat (span - 1) @(posedge clk);
            end
        end
    end

    // idle cycles after a word: mostly none, some short, a few long
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        else if (pick < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic ghh_in_t make_word(input logic kind, input int rx, input int ry,
                                          input int index);
        ghh_in_t word;
        word.kind      = kind;
        word.ratio_x   = RATIO_W'(rx);
        word.ratio_y   = RATIO_W'(ry);
        word.bin_index = INDEX_W'(index);
        return word;
    endfunction

    // ratio on or right next to a bin boundary, 0 and 1.0 included
    function automatic int boundary_ratio();
        int k;
        k = $urandom_range(0, BINS);
        return (k * RATIO_ONE + BINS - 1) / BINS + int'($urandom_range(0, 2)) - 1;
    endfunction

    // mostly samples inside the unit square, with a hot spot so counts grow
    function automatic ghh_in_t random_word();
        ghh_in_t word;
        int      pick;
        pick = $urandom_range(0, 99);
        word = make_word(KIND_SAMPLE, int'($urandom), int'($urandom), int'($urandom));
        if (pick < 25)
        begin
            word.ratio_x = RATIO_W'($urandom_range(1600, 1700));
            word.ratio_y = RATIO_W'($urandom_range(2900, 3000));
        end
        else if (pick < 50)
        begin
            word.ratio_x = RATIO_W'($urandom_range(0, RATIO_ONE));
            word.ratio_y = RATIO_W'($urandom_range(0, RATIO_ONE));
        end
        else if (pick < 60)
        begin
            word.ratio_x = RATIO_W'(boundary_ratio());
            word.ratio_y = RATIO_W'(boundary_ratio());
        end
        else if (pick >= 75)
        begin
            // bin read, now and then past the last bin
            word.kind = KIND_READ;
            if (pick < 97)
                word.bin_index = INDEX_W'($urandom_range(0, BIN_TOTAL - 1));
            else
                word.bin_index = INDEX_W'($urandom_range(BIN_TOTAL, INDEX_TOP));
        end
        return word;
    endfunction

    // hold one word until taken, then maybe idle
    task automatic offer_word(input ghh_in_t word);
        int gap;
        sample_valid <= 1'b1;
        sample_word  <= word;
        do
            @(posedge clk);
        while (sample_stall);
        gap = quiet_mode ? 0 : gap_length();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and wait for every expected word
    task automatic settle_all();
        sample_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        sample_valid  <= 1'b0;
        sample_word   <= '0;
        quiet_mode    <= 1'b1;
        hold_requests <= 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty reads with zero peak, out-of-range reads
        offer_word(make_word(KIND_READ, 16'h7fff, 16'h8000, 0));
        offer_word(make_word(KIND_READ, 0, 0, BIN_TOTAL - 1));
        offer_word(make_word(KIND_READ, 0, 0, BIN_TOTAL));
        offer_word(make_word(KIND_READ, 16'hffff, 16'hffff, INDEX_TOP));
        // corners of the unit square, 1.0 lands in the last bin
        offer_word(make_word(KIND_SAMPLE, 0, 0, INDEX_TOP));
        offer_word(make_word(KIND_SAMPLE, RATIO_ONE, RATIO_ONE, 0));
        offer_word(make_word(KIND_SAMPLE, RATIO_ONE - 1, RATIO_ONE - 1, 5));
        // rejected samples just outside and far outside
        offer_word(make_word(KIND_SAMPLE, -1, 0, 0));
        offer_word(make_word(KIND_SAMPLE, 0, -1, 0));
        offer_word(make_word(KIND_SAMPLE, RATIO_ONE + 1, 0, 0));
        offer_word(make_word(KIND_SAMPLE, 0, RATIO_ONE + 1, 0));
        offer_word(make_word(KIND_SAMPLE, -32768, 32767, 0));
        offer_word(make_word(KIND_SAMPLE, 32767, -32768, 0));
        // bin boundary on each axis, middle of the range
        offer_word(make_word(KIND_SAMPLE, 409, 410, 0));
        offer_word(make_word(KIND_SAMPLE, RATIO_ONE / 2, 0, 0));
        // reads with nonzero peak, the peak bin at full scale and others below it
        offer_word(make_word(KIND_READ, 0, 0, BIN_TOTAL - 1));
        offer_word(make_word(KIND_READ, 0, 0, 5));
        offer_word(make_word(KIND_READ, 16'h7fff, 16'h7fff, 10));
        offer_word(make_word(KIND_SAMPLE, RATIO_ONE, 0, 0));
        offer_word(make_word(KIND_SAMPLE, 0, RATIO_ONE, 0));
        offer_word(make_word(KIND_READ, 0, 0, BIN_TOTAL - BINS));
        offer_word(make_word(KIND_READ, 0, 0, 64));
        settle_all();

        // random phases: first without idling, then with idling on both sides
        for (int phase = 0; phase < 4; phase++)
        begin
            quiet_mode <= (phase == 0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // long receiver hold-off while words keep coming
                if (phase == 2 && n == 100)
                    hold_requests <= hold_requests + 1;
                offer_word(random_word());
            end
            settle_all();
        end

        // one bin hit back to back, then a read of it and a few more words
        quiet_mode <= 1'b1;
        for (int n = 0; n < HOT_WORDS; n++)
            offer_word(make_word(KIND_SAMPLE, int'($urandom_range(HOT_LO, HOT_HI)),
                                 int'($urandom_range(HOT_LO, HOT_HI)), int'($urandom)));
        offer_word(make_word(KIND_READ, 0, 0, 3 + 3 * BINS));
        for (int n = 0; n < 20; n++)
            offer_word(random_word());
        settle_all();

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
sv/ghh_pkg.sv
sv/ghh_bin_store.sv
sv/ghh_level_div.sv
sv/gaze_heatmap_histogram_core.sv
sim/ghh_heatmap_checker.sv
sim/tb_gaze_heatmap_histogram_core.sv
